>>> hw/rtl/smmuc_pkg.sv
package smmuc_pkg;

    // Number of ROM bank counters; the physical bank indexes them directly.
    localparam int BANK_COUNT = 256;
    localparam int BANK_W     = $clog2(BANK_COUNT);

    localparam int ADDR_W = 24;
    localparam int USED_W = 32;
    localparam int CAP_W  = 33;

    // Memory type codes as they appear on the result channel.
    typedef enum logic [2:0] {
        REGION_ROM      = 3'd0,
        REGION_LOW_RAM  = 3'd1,
        REGION_WRAM     = 3'd2,
        REGION_SRAM     = 3'd3,
        REGION_UNKNOWN  = 3'd4
    } region_t;

    // Map mode register values.
    localparam logic MAP_LOROM = 1'b0;
    localparam logic MAP_HIROM = 1'b1;

    // Bank numbers and offset limits used by the address decode.
    localparam logic [7:0]  BANK_WRAM_LO   = 8'h7E;
    localparam logic [7:0]  BANK_WRAM_HI   = 8'h7F;
    localparam logic [7:0]  BANK_LO_SRAM   = 8'h70;
    localparam logic [7:0]  BANK_LO_TOP    = 8'h3F;
    localparam logic [7:0]  BANK_LO_HIGH   = 8'hFE;
    localparam logic [15:0] OFF_LOW_RAM    = 16'h2000;
    localparam logic [15:0] OFF_ROM        = 16'h8000;
    localparam logic [15:0] OFF_HI_SRAM    = 16'h6000;

    // Pool capacities in bytes.
    localparam logic [CAP_W-1:0] CAP_ROM_HALF = 33'h0_0000_8000;
    localparam logic [CAP_W-1:0] CAP_ROM_FULL = 33'h0_0001_0000;
    localparam logic [CAP_W-1:0] CAP_WRAM     = 33'h0_0001_0000;
    localparam logic [CAP_W-1:0] CAP_LOW_RAM  = 33'h0_0000_2000;
    localparam logic [CAP_W-1:0] CAP_SRAM_MIN = 33'h0_0000_0800;
    localparam logic [CAP_W-1:0] CAP_NONE     = 33'h0_0000_0000;

endpackage

>>> hw/rtl/smmuc_if.sv
// Section channel: one beat carries one section's address range.
interface smmuc_in_if import smmuc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] start_address;
    logic [ADDR_W-1:0] end_address;

    modport source (output valid, output start_address, output end_address, input ready);
    modport sink (input valid, input start_address, input end_address, output ready);
endinterface

// Report channel: one beat carries the usage result for one section.
interface smmuc_out_if import smmuc_pkg::*; ();
    logic              valid;
    logic              ready;
    region_t           region;
    logic [7:0]        phys_bank;
    logic              bank_valid;
    logic [ADDR_W-1:0] section_size;
    logic [USED_W-1:0] pool_used;
    logic [CAP_W-1:0]  pool_capacity;
    logic              over_capacity;

    modport source (output valid, output region, output phys_bank, output bank_valid,
                    output section_size, output pool_used, output pool_capacity,
                    output over_capacity, input ready);
    modport sink (input valid, input region, input phys_bank, input bank_valid,
                  input section_size, input pool_used, input pool_capacity,
                  input over_capacity, output ready);
endinterface

>>> hw/rtl/snes_memory_map_usage_classifier_top.sv
// Channel    Dir   Handshake      Payload
// section    in    valid/ready    start_address[23:0], end_address[23:0]
// report     out   valid/ready    region, phys_bank, bank_valid, section_size,
//                                 pool_used, pool_capacity, over_capacity
// cfg        in    cfg_we only    cfg_wdata = map_mode
//
// One section is accepted per cycle unless a stalled report holds the pipeline;
// each report passes the input/decode, read/accumulate, capacity and report stages.
// The ROM bank counters live in a 256-entry memory with one read and one write
// port; a bypass from the last write keeps back-to-back updates exact.
// Reset clears all counters at once through per-bank valid bits; no sweep.
// A stalled report holds the whole pipeline; the section side keeps accepting
// until the four stages are full.
module snes_memory_map_usage_classifier_top import smmuc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    smmuc_in_if.sink     section,
    smmuc_out_if.source  report
);

    // Map mode register.
    logic map_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_mode_reg <= MAP_LOROM;
        end
        else if (cfg_we)
        begin
            map_mode_reg <= cfg_wdata;
        end
    end

    // Pipeline occupancy and advance conditions.
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic a_adv, b_adv, c_adv, d_adv;

    assign d_adv = !d_valid_reg || report.ready;
    assign c_adv = !c_valid_reg || d_adv;
    assign b_adv = !b_valid_reg || c_adv;
    assign a_adv = !a_valid_reg || b_adv;

    assign section.ready = a_adv;

    // Stage A: input register.
    logic [ADDR_W-1:0] a_start_reg;
    logic [ADDR_W-1:0] a_end_reg;

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            a_start_reg <= section.start_address;
            a_end_reg   <= section.end_address;
        end
    end

    // Stage A logic: section size and address decode.
    logic [7:0]        a_bank;
    logic [15:0]       a_off;
    logic              a_sys_bank;
    logic [ADDR_W-1:0] a_size;
    region_t           a_region;
    logic [7:0]        a_pb;
    logic [CAP_W-1:0]  a_cap;

    assign a_bank = a_start_reg[23:16];
    assign a_off  = a_start_reg[15:0];
    assign a_size = (a_end_reg >= a_start_reg) ? (a_end_reg - a_start_reg) : '0;

    // System banks: 00-3F/80-BF in LoROM, 00-1F/80-9F in HiROM.
    assign a_sys_bank = (map_mode_reg == MAP_HIROM) ? (a_bank[6:5] == 2'b00)
                                                    : (a_bank[6] == 1'b0);

    always_comb
    begin
        a_region = REGION_UNKNOWN;
        a_pb     = a_bank;
        a_cap    = CAP_NONE;
        if (a_bank == BANK_WRAM_LO || a_bank == BANK_WRAM_HI)
        begin
            a_region = REGION_WRAM;
            a_cap    = CAP_WRAM;
        end
        else if (a_off < OFF_LOW_RAM && a_sys_bank)
        begin
            a_region = REGION_LOW_RAM;
            a_pb     = 8'h00;
            a_cap    = CAP_LOW_RAM;
        end
        else if (map_mode_reg == MAP_LOROM)
        begin
            if (a_bank >= BANK_LO_HIGH)
            begin
                // Top two banks keep their number.
                if (a_off < OFF_ROM)
                begin
                    a_region = REGION_SRAM;
                end
                else
                begin
                    a_region = REGION_ROM;
                    a_cap    = CAP_ROM_HALF;
                end
            end
            else
            begin
                a_pb = {1'b0, a_bank[6:0]};
                if ({1'b0, a_bank[6:0]} >= BANK_LO_SRAM)
                begin
                    if (a_off < OFF_ROM)
                    begin
                        a_region = REGION_SRAM;
                    end
                    else
                    begin
                        a_region = REGION_ROM;
                        a_cap    = CAP_ROM_HALF;
                    end
                end
                else if ({1'b0, a_bank[6:0]} <= BANK_LO_TOP)
                begin
                    if (a_off >= OFF_ROM)
                    begin
                        a_region = REGION_ROM;
                        a_cap    = CAP_ROM_HALF;
                    end
                end
                else
                begin
                    a_region = REGION_ROM;
                    a_cap    = CAP_ROM_FULL;
                end
            end
        end
        else
        begin
            // HiROM: every path charges bank & 0x3F.
            a_pb = {2'b00, a_bank[5:0]};
            if (a_bank[6] || a_off >= OFF_ROM)
            begin
                a_region = REGION_ROM;
                a_cap    = CAP_ROM_FULL;
            end
            else if (a_bank[5] && a_off >= OFF_HI_SRAM)
            begin
                a_region = REGION_SRAM;
            end
        end
    end

    // ROM bank counter memory, valid bits and read port.
    logic [USED_W-1:0] rom_mem [BANK_COUNT];
    logic [BANK_COUNT-1:0] rom_vld_reg;
    logic [USED_W-1:0] rd_data_reg;
    logic              rd_vld_reg;
    logic              rom_we;
    logic [USED_W-1:0] b_used;

    // Stage B registers.
    region_t           b_region_reg;
    logic [7:0]        b_pb_reg;
    logic [ADDR_W-1:0] b_size_reg;
    logic [CAP_W-1:0]  b_cap_reg;

    assign rom_we = b_valid_reg && c_adv && (b_region_reg == REGION_ROM);

    // The read is taken as the item moves into stage B, so it stays put while B stalls.
    always_ff @(posedge clk)
    begin
        if (rom_we)
        begin
            rom_mem[b_pb_reg[BANK_W-1:0]] <= b_used;
        end
        if (b_adv)
        begin
            rd_data_reg <= rom_mem[a_pb[BANK_W-1:0]];
        end
    end

    // Bypass of the most recent ROM write, which the read in the same cycle misses.
    logic              lw_valid_reg;
    logic [7:0]        lw_pb_reg;
    logic [USED_W-1:0] lw_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_vld_reg  <= '0;
            rd_vld_reg   <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            if (rom_we)
            begin
                rom_vld_reg[b_pb_reg[BANK_W-1:0]] <= 1'b1;
                lw_valid_reg <= 1'b1;
            end
            if (b_adv)
            begin
                rd_vld_reg <= rom_vld_reg[a_pb[BANK_W-1:0]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rom_we)
        begin
            lw_pb_reg   <= b_pb_reg;
            lw_data_reg <= b_used;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            b_region_reg <= a_region;
            b_pb_reg     <= a_pb;
            b_size_reg   <= a_size;
            b_cap_reg    <= a_cap;
        end
    end

    // Scalar pool counters.
    logic [USED_W-1:0] wram_lo_used_reg;
    logic [USED_W-1:0] wram_hi_used_reg;
    logic [USED_W-1:0] low_ram_used_reg;
    logic [USED_W-1:0] sram_used_reg;
    logic [USED_W-1:0] unknown_used_reg;

    // Stage B logic: select the pool's current total and add with saturation.
    logic [USED_W-1:0] b_rom_old;
    logic [USED_W-1:0] b_old;
    logic [USED_W:0]   b_sum;

    always_comb
    begin
        if (lw_valid_reg && lw_pb_reg == b_pb_reg)
        begin
            b_rom_old = lw_data_reg;
        end
        else if (rd_vld_reg)
        begin
            b_rom_old = rd_data_reg;
        end
        else
        begin
            b_rom_old = '0;
        end
    end

    always_comb
    begin
        case (b_region_reg)
            REGION_ROM:     b_old = b_rom_old;
            REGION_WRAM:    b_old = b_pb_reg[0] ? wram_hi_used_reg : wram_lo_used_reg;
            REGION_LOW_RAM: b_old = low_ram_used_reg;
            REGION_SRAM:    b_old = sram_used_reg;
            default:        b_old = unknown_used_reg;
        endcase
    end

    assign b_sum  = {1'b0, b_old} + {{(USED_W + 1 - ADDR_W){1'b0}}, b_size_reg};
    assign b_used = b_sum[USED_W] ? '1 : b_sum[USED_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wram_lo_used_reg <= '0;
            wram_hi_used_reg <= '0;
            low_ram_used_reg <= '0;
            sram_used_reg    <= '0;
            unknown_used_reg <= '0;
        end
        else if (b_valid_reg && c_adv)
        begin
            case (b_region_reg)
                REGION_ROM:
                begin
                end
                REGION_WRAM:
                begin
                    if (b_pb_reg[0])
                    begin
                        wram_hi_used_reg <= b_used;
                    end
                    else
                    begin
                        wram_lo_used_reg <= b_used;
                    end
                end
                REGION_LOW_RAM: low_ram_used_reg <= b_used;
                REGION_SRAM:    sram_used_reg    <= b_used;
                default:        unknown_used_reg <= b_used;
            endcase
        end
    end

    // Stage C registers.
    region_t           c_region_reg;
    logic [7:0]        c_pb_reg;
    logic [ADDR_W-1:0] c_size_reg;
    logic [CAP_W-1:0]  c_cap_reg;
    logic [USED_W-1:0] c_used_reg;

    always_ff @(posedge clk)
    begin
        if (c_adv)
        begin
            c_region_reg <= b_region_reg;
            c_pb_reg     <= b_pb_reg;
            c_size_reg   <= b_size_reg;
            c_cap_reg    <= b_cap_reg;
            c_used_reg   <= b_used;
        end
    end

    // Stage C logic: SRAM capacity rounds the total up to a power of two.
    logic [USED_W-1:0] c_smear;
    logic [CAP_W-1:0]  c_pow2;
    logic [CAP_W-1:0]  c_cap;
    logic              c_over;

    always_comb
    begin
        c_smear = c_used_reg - USED_W'(1);
        c_smear = c_smear | (c_smear >> 1);
        c_smear = c_smear | (c_smear >> 2);
        c_smear = c_smear | (c_smear >> 4);
        c_smear = c_smear | (c_smear >> 8);
        c_smear = c_smear | (c_smear >> 16);
    end

    assign c_pow2 = {1'b0, c_smear} + CAP_W'(1);

    always_comb
    begin
        if (c_region_reg == REGION_SRAM)
        begin
            c_cap = ({1'b0, c_used_reg} <= CAP_SRAM_MIN) ? CAP_SRAM_MIN : c_pow2;
        end
        else
        begin
            c_cap = c_cap_reg;
        end
    end

    assign c_over = (c_cap != CAP_NONE) && ({1'b0, c_used_reg} > c_cap);

    // Stage D: report register.
    region_t           d_region_reg;
    logic [7:0]        d_pb_reg;
    logic              d_bank_valid_reg;
    logic [ADDR_W-1:0] d_size_reg;
    logic [USED_W-1:0] d_used_reg;
    logic [CAP_W-1:0]  d_cap_reg;
    logic              d_over_reg;

    always_ff @(posedge clk)
    begin
        if (d_adv)
        begin
            d_region_reg     <= c_region_reg;
            d_pb_reg         <= c_pb_reg;
            d_bank_valid_reg <= (c_region_reg != REGION_LOW_RAM);
            d_size_reg       <= c_size_reg;
            d_used_reg       <= c_used_reg;
            d_cap_reg        <= c_cap;
            d_over_reg       <= c_over;
        end
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
            begin
                a_valid_reg <= section.valid;
            end
            if (b_adv)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_adv)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_adv)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    assign report.valid         = d_valid_reg;
    assign report.region        = d_region_reg;
    assign report.phys_bank     = d_pb_reg;
    assign report.bank_valid    = d_bank_valid_reg;
    assign report.section_size  = d_size_reg;
    assign report.pool_used     = d_used_reg;
    assign report.pool_capacity = d_cap_reg;
    assign report.over_capacity = d_over_reg;

endmodule

>>> hw/rtl/smmuc_checker.sv
module smmuc_checker import smmuc_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              rpt_valid,
    input logic              rpt_ready,
    input region_t           rpt_region,
    input logic [7:0]        rpt_phys_bank,
    input logic              rpt_bank_valid,
    input logic [USED_W-1:0] rpt_pool_used,
    input logic [CAP_W-1:0]  rpt_pool_capacity,
    input logic              rpt_over_capacity
);

    // A stalled report beat stays up with its running total unchanged.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && !rpt_ready |=> rpt_valid && $stable(rpt_pool_used))
        else $error("stalled report beat dropped or changed");

    // The low RAM pool is aggregated and carries no bank.
    a_low_ram_bank: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && rpt_region == REGION_LOW_RAM |-> !rpt_bank_valid && rpt_phys_bank == 8'h00)
        else $error("low RAM report carries a bank");

    // Unknown sections have no capacity and are never flagged.
    a_unknown_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && rpt_region == REGION_UNKNOWN
        |-> rpt_pool_capacity == CAP_NONE && !rpt_over_capacity && rpt_bank_valid)
        else $error("unknown region reports capacity");

    // SRAM capacity always covers the total and is at least the minimum size.
    a_sram_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && rpt_region == REGION_SRAM
        |-> !rpt_over_capacity && rpt_pool_capacity >= CAP_SRAM_MIN
            && rpt_pool_capacity >= {1'b0, rpt_pool_used})
        else $error("SRAM capacity does not cover its total");

endmodule

bind snes_memory_map_usage_classifier_top smmuc_checker u_smmuc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rpt_valid         (report.valid),
    .rpt_ready         (report.ready),
    .rpt_region        (report.region),
    .rpt_phys_bank     (report.phys_bank),
    .rpt_bank_valid    (report.bank_valid),
    .rpt_pool_used     (report.pool_used),
    .rpt_pool_capacity (report.pool_capacity),
    .rpt_over_capacity (report.over_capacity)
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import smmuc_pkg::*;

    // One usage report as it leaves the block.
    typedef struct packed {
        region_t           region;
        logic [7:0]        phys_bank;
        logic              bank_valid;
        logic [ADDR_W-1:0] section_size;
        logic [USED_W-1:0] pool_used;
        logic [CAP_W-1:0]  pool_capacity;
        logic              over_capacity;
    } report_t;

    // One row of the directed table; typed rows carry their report.
    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] sec_start;
        logic [ADDR_W-1:0] sec_end;
        logic              typed;
        report_t           rep;
    } section_row_t;

    localparam report_t NO_TYPED = '{REGION_ROM, 8'h00, 1'b0, 24'h0, 32'h0, 33'h0, 1'b0};
    localparam int      REPORT_HOLD_CYCLES = 60;
    localparam int      FLOOD_SECTIONS = 1000;
    localparam int      RANDOM_PHASES = 5;
    localparam int      PHASE_SECTIONS = 130;

    // Banks and offsets that sit on decode boundaries.
    localparam logic [19:0][7:0] EDGE_BANKS = {
        8'h00, 8'h1F, 8'h20, 8'h3F, 8'h40, 8'h6F, 8'h70, 8'h7D, 8'h7E, 8'h7F,
        8'h80, 8'h9F, 8'hA0, 8'hBF, 8'hC0, 8'hEF, 8'hF0, 8'hFD, 8'hFE, 8'hFF
    };
    localparam logic [7:0][15:0] EDGE_OFFSETS = {
        16'h0000, 16'h1FFF, 16'h2000, 16'h5FFF, 16'h6000, 16'h7FFF, 16'h8000, 16'hFFFF
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    smmuc_in_if  section_ch ();
    smmuc_out_if report_ch ();

    snes_memory_map_usage_classifier_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .section   (section_ch),
        .report    (report_ch)
    );

    // Shadow copy of the usage counters and the map mode.
    logic [USED_W-1:0] rom_bank_total [BANK_COUNT];
    logic [USED_W-1:0] wram_lo_used;
    logic [USED_W-1:0] wram_hi_used;
    logic [USED_W-1:0] low_ram_used;
    logic [USED_W-1:0] sram_used;
    logic [USED_W-1:0] unknown_used;
    logic              map_mode_q;

    report_t      pending_reports [$];
    section_row_t section_table [$];

    int  fault_count;
    int  sent_count;
    int  checked_count;
    int  mode_writes;
    int  saturated_count;
    int  over_count;
    int  full_cap_count;
    int  report_hold;
    bit  send_burst;

    // Clock: 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Hard limit on the run time.
    initial
    begin
        #6_000_000;
        $display("snes_memory_map_usage_classifier_top test failed");
        $finish;
    end

    function automatic logic [USED_W-1:0] sat_add32(input logic [USED_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b);
        logic [USED_W:0] sum;
        sum = {1'b0, a} + {9'b0, b};
        return sum[USED_W] ? {USED_W{1'b1}} : sum[USED_W-1:0];
    endfunction

    // Decode the start address, charge the pool and build the report.
    function automatic report_t predict_report(input logic [ADDR_W-1:0] sa,
                                               input logic [ADDR_W-1:0] ea);
        report_t     r;
        logic [7:0]  bank;
        logic [7:0]  pb;
        logic [15:0] off;
        logic        sys_bank;
        bank = sa[23:16];
        off = sa[15:0];
        pb = 8'h00;
        r = NO_TYPED;
        r.bank_valid = 1'b1;
        r.section_size = (ea >= sa) ? ea - sa : '0;
        if (map_mode_q == MAP_LOROM)
            sys_bank = (bank <= 8'h3F) || (bank >= 8'h80 && bank <= 8'hBF);
        else
            sys_bank = (bank <= 8'h1F) || (bank >= 8'h80 && bank <= 8'h9F);

        if (bank == BANK_WRAM_LO || bank == BANK_WRAM_HI)
        begin
            r.region = REGION_WRAM;
            pb = bank;
        end
        else if (off < OFF_LOW_RAM && sys_bank)
        begin
            r.region = REGION_LOW_RAM;
            r.bank_valid = 1'b0;
        end
        else if (map_mode_q == MAP_LOROM)
        begin
            if (bank >= 8'hFE)
            begin
                pb = bank;
                r.region = (off < OFF_ROM) ? REGION_SRAM : REGION_ROM;
            end
            else
            begin
                pb = (bank >= 8'h80) ? bank - 8'h80 : bank;
                if (pb >= 8'h70)
                    r.region = (off < OFF_ROM) ? REGION_SRAM : REGION_ROM;
                else if (pb <= 8'h3F)
                    r.region = (off < OFF_ROM) ? REGION_UNKNOWN : REGION_ROM;
                else
                    r.region = REGION_ROM;
            end
        end
        else
        begin
            if (bank >= 8'h40 && bank <= 8'h7D)
            begin
                r.region = REGION_ROM;
                pb = bank - 8'h40;
            end
            else if (bank >= 8'hC0)
            begin
                r.region = REGION_ROM;
                pb = bank - 8'hC0;
            end
            else
            begin
                pb = bank & 8'h3F;
                if (off >= OFF_ROM)
                    r.region = REGION_ROM;
                else if (((bank >= 8'h20 && bank <= 8'h3F) || (bank >= 8'hA0 && bank <= 8'hBF))
                         && off >= OFF_HI_SRAM)
                    r.region = REGION_SRAM;
                else
                    r.region = REGION_UNKNOWN;
            end
        end
        r.phys_bank = pb;

        // Accumulate into the selected pool.
        case (r.region)
            REGION_ROM:
            begin
                rom_bank_total[pb] = sat_add32(rom_bank_total[pb], r.section_size);
                r.pool_used = rom_bank_total[pb];
                if (map_mode_q == MAP_HIROM)
                    r.pool_capacity = CAP_ROM_FULL;
                else if (pb >= 8'h40 && pb <= 8'h6F)
                    r.pool_capacity = CAP_ROM_FULL;
                else
                    r.pool_capacity = CAP_ROM_HALF;
            end
            REGION_WRAM:
            begin
                if (pb == BANK_WRAM_LO)
                begin
                    wram_lo_used = sat_add32(wram_lo_used, r.section_size);
                    r.pool_used = wram_lo_used;
                end
                else
                begin
                    wram_hi_used = sat_add32(wram_hi_used, r.section_size);
                    r.pool_used = wram_hi_used;
                end
                r.pool_capacity = CAP_WRAM;
            end
            REGION_LOW_RAM:
            begin
                low_ram_used = sat_add32(low_ram_used, r.section_size);
                r.pool_used = low_ram_used;
                r.pool_capacity = CAP_LOW_RAM;
            end
            REGION_SRAM:
            begin
                sram_used = sat_add32(sram_used, r.section_size);
                r.pool_used = sram_used;
                r.pool_capacity = CAP_SRAM_MIN;
                while (r.pool_capacity < {1'b0, r.pool_used})
                    r.pool_capacity = r.pool_capacity << 1;
            end
            default:
            begin
                unknown_used = sat_add32(unknown_used, r.section_size);
                r.pool_used = unknown_used;
                r.pool_capacity = CAP_NONE;
            end
        endcase
        r.over_capacity = (r.pool_capacity != CAP_NONE) &&
                          ({1'b0, r.pool_used} > r.pool_capacity);
        return r;
    endfunction

    // Random section, biased toward decode boundaries and odd sizes.
    function automatic void pick_section(output logic [ADDR_W-1:0] sa,
                                         output logic [ADDR_W-1:0] ea);
        logic [7:0]  bank;
        logic [15:0] off;
        int unsigned kind;
        bank = ($urandom_range(0, 1) == 0) ? EDGE_BANKS[$urandom_range(0, 19)]
                                           : 8'($urandom_range(0, 255));
        off = ($urandom_range(0, 9) < 8) ? EDGE_OFFSETS[$urandom_range(0, 7)]
                                          : 16'($urandom());
        sa = {bank, off};
        kind = $urandom_range(0, 9);
        if (kind <= 4)
            ea = sa + 24'($urandom_range(0, 16'hFFFF));
        else if (kind == 5)
            ea = 24'($urandom_range(0, int'(sa)));
        else if (kind <= 7)
            ea = 24'hFFFFFF - 24'($urandom_range(0, 255));
        else
        begin
            sa = 24'($urandom());
            ea = 24'($urandom());
        end
    endfunction

    // Offer one section beat and log its report once accepted.
    task automatic send_section(input logic [ADDR_W-1:0] sa, input logic [ADDR_W-1:0] ea,
                                input logic typed, input report_t typed_rep);
        int unsigned gap;
        report_t     pred;
        gap = send_burst ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            section_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        section_ch.valid <= 1'b1;
        section_ch.start_address <= sa;
        section_ch.end_address <= ea;
        do @(posedge clk); while (!section_ch.ready);
        pred = predict_report(sa, ea);
        pending_reports.push_back(typed ? typed_rep : pred);
        sent_count++;
    endtask

    // Wait for the block to drain, then change the map mode.
    task automatic write_map_mode(input logic mode);
        section_ch.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        map_mode_q = mode;
        mode_writes++;
    endtask

    // Report side: random stalls, one long hold-off on request, and checking.
    initial
    begin : report_sink
        int unsigned gap;
        bit          recv_burst;
        report_t     exp_rep;
        report_t     got;
        recv_burst = 1'b0;
        report_ch.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (report_hold != 0)
            begin
                report_ch.ready <= 1'b0;
                repeat (report_hold) @(posedge clk);
                report_hold = 0;
            end
            if (checked_count % 64 == 0)
                recv_burst = ($urandom_range(0, 3) == 0);
            gap = recv_burst ? 0 : $urandom_range(0, 5);
            if (gap != 0)
            begin
                report_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            report_ch.ready <= 1'b1;
            do @(posedge clk); while (!report_ch.valid);

            got.region = report_ch.region;
            got.phys_bank = report_ch.phys_bank;
            got.bank_valid = report_ch.bank_valid;
            got.section_size = report_ch.section_size;
            got.pool_used = report_ch.pool_used;
            got.pool_capacity = report_ch.pool_capacity;
            got.over_capacity = report_ch.over_capacity;
            checked_count++;
            if (got.pool_used == {USED_W{1'b1}})
                saturated_count++;
            if (got.over_capacity)
                over_count++;
            if (got.pool_capacity[CAP_W-1])
                full_cap_count++;

            if (pending_reports.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected report beat: region=%0d bank=%h used=%h",
                             got.region, got.phys_bank, got.pool_used);
            end
            else
            begin
                exp_rep = pending_reports.pop_front();
                if (got.region !== exp_rep.region || got.phys_bank !== exp_rep.phys_bank ||
                    got.bank_valid !== exp_rep.bank_valid ||
                    got.section_size !== exp_rep.section_size ||
                    got.pool_used !== exp_rep.pool_used ||
                    got.pool_capacity !== exp_rep.pool_capacity ||
                    got.over_capacity !== exp_rep.over_capacity)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                    begin
                        $display("report %0d mismatch, expected: region=%0d bank=%h bv=%0d size=%h used=%h cap=%h over=%0d",
                                 checked_count, exp_rep.region, exp_rep.phys_bank,
                                 exp_rep.bank_valid, exp_rep.section_size, exp_rep.pool_used,
                                 exp_rep.pool_capacity, exp_rep.over_capacity);
                        $display("report %0d mismatch, actual:   region=%0d bank=%h bv=%0d size=%h used=%h cap=%h over=%0d",
                                 checked_count, got.region, got.phys_bank, got.bank_valid,
                                 got.section_size, got.pool_used, got.pool_capacity,
                                 got.over_capacity);
                    end
                end
            end
        end
    end

    // Stimulus: reset, directed table, flood toward saturation, random phases.
    initial
    begin : stimulus
        logic [ADDR_W-1:0] sa;
        logic [ADDR_W-1:0] ea;
        section_row_t      row;
        int unsigned       pick;
        bit                mode_set;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= 1'b0;
        section_ch.valid <= 1'b0;
        section_ch.start_address <= '0;
        section_ch.end_address <= '0;
        fault_count = 0;
        sent_count = 0;
        checked_count = 0;
        mode_writes = 0;
        saturated_count = 0;
        over_count = 0;
        full_cap_count = 0;
        report_hold = 0;
        send_burst = 1'b0;
        mode_set = 1'b0;
        map_mode_q = MAP_LOROM;
        wram_lo_used = '0;
        wram_hi_used = '0;
        low_ram_used = '0;
        sram_used = '0;
        unknown_used = '0;
        foreach (rom_bank_total[i])
            rom_bank_total[i] = '0;

        // LoROM rows; typed reports assume counters fresh from reset plus the rows sent before.
        section_table.push_back('{MAP_LOROM, 24'h000000, 24'h000FFF, 1'b1,
            '{REGION_LOW_RAM, 8'h00, 1'b0, 24'h000FFF, 32'h0000_0FFF, CAP_LOW_RAM, 1'b0}});
        section_table.push_back('{MAP_LOROM, 24'h7E0000, 24'h7EFFFF, 1'b1,
            '{REGION_WRAM, 8'h7E, 1'b1, 24'h00FFFF, 32'h0000_FFFF, CAP_WRAM, 1'b0}});
        section_table.push_back('{MAP_LOROM, 24'h7F0010, 24'h7F0000, 1'b1,
            '{REGION_WRAM, 8'h7F, 1'b1, 24'h000000, 32'h0000_0000, CAP_WRAM, 1'b0}});
        section_table.push_back('{MAP_LOROM, 24'h008000, 24'h00FFFF, 1'b1,
            '{REGION_ROM, 8'h00, 1'b1, 24'h007FFF, 32'h0000_7FFF, CAP_ROM_HALF, 1'b0}});
        section_table.push_back('{MAP_LOROM, 24'h002000, 24'h0020FF, 1'b1,
            '{REGION_UNKNOWN, 8'h00, 1'b1, 24'h0000FF, 32'h0000_00FF, CAP_NONE, 1'b0}});
        section_table.push_back('{MAP_LOROM, 24'hFF0000, 24'hFFFFFF, 1'b1,
            '{REGION_SRAM, 8'hFF, 1'b1, 24'h00FFFF, 32'h0000_FFFF, 33'h0_0001_0000, 1'b0}});
        section_table.push_back('{MAP_LOROM, 24'h000000, 24'hFFFFFF, 1'b1,
            '{REGION_LOW_RAM, 8'h00, 1'b0, 24'hFFFFFF, 32'h0100_0FFE, CAP_LOW_RAM, 1'b1}});
        section_table.push_back('{MAP_LOROM, 24'hFFFFFF, 24'hFFFFFF, 1'b1,
            '{REGION_ROM, 8'hFF, 1'b1, 24'h000000, 32'h0000_0000, CAP_ROM_HALF, 1'b0}});
        section_table.push_back('{MAP_LOROM, 24'h808000, 24'h80FFFF, 1'b0, NO_TYPED});
        section_table.push_back('{MAP_LOROM, 24'h400000, 24'h40FFFF, 1'b0, NO_TYPED});
        section_table.push_back('{MAP_LOROM, 24'hC08000, 24'hC0FFFF, 1'b0, NO_TYPED});
        section_table.push_back('{MAP_LOROM, 24'h700000, 24'h707FFF, 1'b0, NO_TYPED});
        section_table.push_back('{MAP_LOROM, 24'hF08000, 24'hF0FFFF, 1'b0, NO_TYPED});
        section_table.push_back('{MAP_LOROM, 24'hFE7FFF, 24'hFE8000, 1'b0, NO_TYPED});
        section_table.push_back('{MAP_LOROM, 24'h3F1FFF, 24'h3F2000, 1'b0, NO_TYPED});
        section_table.push_back('{MAP_LOROM, 24'h6FFFFF, 24'h000000, 1'b0, NO_TYPED});
        // HiROM rows.
        section_table.push_back('{MAP_HIROM, 24'h000000, 24'h001FFF, 1'b0, NO_TYPED});
        section_table.push_back('{MAP_HIROM, 24'h200000, 24'h205FFF, 1'b0, NO_TYPED});
        section_table.push_back('{MAP_HIROM, 24'h206000, 24'h207FFF, 1'b0, NO_TYPED});
        section_table.push_back('{MAP_HIROM, 24'h408000, 24'h40FFFF, 1'b0, NO_TYPED});
        section_table.push_back('{MAP_HIROM, 24'h7D0000, 24'h7DFFFF, 1'b0, NO_TYPED});
        section_table.push_back('{MAP_HIROM, 24'hC00000, 24'hC0FFFF, 1'b0, NO_TYPED});
        section_table.push_back('{MAP_HIROM, 24'hA07FFF, 24'hA08000, 1'b0, NO_TYPED});
        section_table.push_back('{MAP_HIROM, 24'h9F1FFF, 24'h9F2000, 1'b0, NO_TYPED});
        section_table.push_back('{MAP_HIROM, 24'hBFFFFF, 24'hFFFFFF, 1'b0, NO_TYPED});
        section_table.push_back('{MAP_HIROM, 24'h7E0000, 24'h7E0001, 1'b0, NO_TYPED});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, switching the map mode between blocks of rows.
        foreach (section_table[i])
        begin
            row = section_table[i];
            if (!mode_set || row.mode != map_mode_q)
            begin
                write_map_mode(row.mode);
                mode_set = 1'b1;
            end
            send_section(row.sec_start, row.sec_end, row.typed, row.rep);
        end

        // Flood: near-maximum sections into low RAM, SRAM and unknown pools
        // under HiROM, so that counters saturate and SRAM capacity reaches 2^32.
        write_map_mode(MAP_HIROM);
        for (int n = 0; n < FLOOD_SECTIONS; n++)
        begin
            if (n % 64 == 0)
                send_burst = ($urandom_range(0, 3) == 0);
            if (n == 200)
                report_hold = REPORT_HOLD_CYCLES;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                pick_section(sa, ea);
            else
            begin
                if (pick < 35)
                    sa = {8'h00, 3'b000, 13'($urandom())};
                else if (pick < 67)
                    sa = {8'h20, 16'h6000 + 16'($urandom_range(0, 16'h1FFF))};
                else
                    sa = {8'h20, 16'($urandom_range(0, 16'h5FFF))};
                ea = 24'hFFFFFF - 24'($urandom_range(0, 15));
            end
            send_section(sa, ea, 1'b0, NO_TYPED);
        end

        // Random phases over both maps.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_map_mode((p < 4) ? p[0] : 1'($urandom_range(0, 1)));
            for (int n = 0; n < PHASE_SECTIONS; n++)
            begin
                if (n % 64 == 0)
                    send_burst = ($urandom_range(0, 3) == 0);
                if (p == 0 && n == 40)
                    report_hold = REPORT_HOLD_CYCLES;
                pick_section(sa, ea);
                send_section(sa, ea, 1'b0, NO_TYPED);
            end
        end

        // Drain and let a few more cycles pass for any stray beat.
        section_ch.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Ran %0d sections through %0d map mode settings; %0d reports checked.",
                 sent_count, mode_writes, checked_count);
        $display("Saturated pool reports: %0d, over capacity: %0d, 2^32 capacity: %0d.",
                 saturated_count, over_count, full_cap_count);
        if (fault_count == 0 && pending_reports.size() == 0)
            $display("snes_memory_map_usage_classifier_top test passed");
        else
            $display("snes_memory_map_usage_classifier_top test failed");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/smmuc_pkg.sv
hw/rtl/smmuc_if.sv
hw/rtl/snes_memory_map_usage_classifier_top.sv
hw/rtl/smmuc_checker.sv
tb/tb_top.sv
